/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the slab handle allocator.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = 4;   // slot number
  localparam int unsigned LINK_W    = 5;   // slot number or null
  localparam int unsigned MAX_ELEMS = 64;
  localparam int unsigned ELEM_W    = 6;   // element index
  localparam int unsigned ECNT_W    = 7;   // element index or null, counts
  localparam int unsigned ADDR_W    = SLOT_W + ELEM_W;

  localparam logic [LINK_W-1:0] BLK_NIL = LINK_W'(NUM_SLOTS);
  localparam logic [ECNT_W-1:0] ELM_NIL = ECNT_W'(MAX_ELEMS);

  // configuration register indexes
  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_GROW       = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ALLOC_FAIL = 2'd1,
    STATUS_BAD_FREE   = 2'd2
  } status_e;

  // one word of the element memory
  typedef struct packed {
    logic              used;
    logic [ECNT_W-1:0] link;
  } elem_word_t;

endpackage

/* rtl/sha_if.sv */
// ----------------------------------------------------------------------------
// sha_req_if / sha_rsp_if
// Valid/ready channels of the slab handle allocator.
// ----------------------------------------------------------------------------
interface sha_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [sha_pkg::SLOT_W-1:0] free_block;
  logic [sha_pkg::ELEM_W-1:0] free_index;

  modport source (output valid, operation, free_block, free_index, input ready);
  modport sink   (input valid, operation, free_block, free_index, output ready);
endinterface

interface sha_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [sha_pkg::SLOT_W-1:0] handle_block;
  logic [sha_pkg::ELEM_W-1:0] handle_index;
  logic [10:0]               in_use_total;
  logic [4:0]                blocks_active;
  logic [31:0]               allocs_total;
  logic [31:0]               frees_total;
  logic [31:0]               fails_total;

  modport source (output valid, status, handle_block, handle_index, in_use_total,
                  blocks_active, allocs_total, frees_total, fails_total,
                  input ready);
  modport sink   (input valid, status, handle_block, handle_index, in_use_total,
                  blocks_active, allocs_total, frees_total, fails_total,
                  output ready);
endinterface

/* rtl/slab_handle_allocator.sv */
// ----------------------------------------------------------------------------
// slab_handle_allocator
// Slab allocator over 16 block slots with a LIFO free list per block.
// ----------------------------------------------------------------------------
// One word in, one result word out. A free checks the slot and reads the
// element memory, updates, and hands off the result. An allocation walks
// the block list one slot per cycle past the full blocks ahead of the first
// block with a free element (up to 16), creates a block when none has one
// and growth is enabled or the list is empty (else fails), pops the head
// element and reads its link from memory when the element was freed before.
// A new block needs no clearing sweep: untouched elements are served from a
// per-block bump pointer, and only handed-out elements live in the memory.
// The next word is taken while the previous result waits at the output.
module slab_handle_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [sha_pkg::ECNT_W-1:0] cfg_data_i,
  sha_req_if.sink                    req_i,
  sha_rsp_if.source                  rsp_o
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_CREATE = 3'd2;
  localparam logic [2:0] ST_POP    = 3'd3;
  localparam logic [2:0] ST_ARD    = 3'd4;
  localparam logic [2:0] ST_FCHK   = 3'd5;
  localparam logic [2:0] ST_FRD    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // configuration
  logic [ECNT_W-1:0] blk_size_q;
  logic              grow_q;

  // control
  logic [2:0]        state_q, state_d;
  logic [LINK_W-1:0] cur_q, cur_d;       // block under work
  logic [LINK_W-1:0] walk_q, walk_d;     // blocks visited
  logic [SLOT_W-1:0] fblk_q, fblk_d;
  logic [ELEM_W-1:0] fidx_q, fidx_d;

  // block table
  logic [NUM_SLOTS-1:0] act_q, act_d;
  logic [LINK_W-1:0]    nxt_q [NUM_SLOTS], nxt_d [NUM_SLOTS];
  logic [LINK_W-1:0]    prv_q [NUM_SLOTS], prv_d [NUM_SLOTS];
  logic [ECNT_W-1:0]    fhead_q [NUM_SLOTS], fhead_d [NUM_SLOTS];
  logic [ECNT_W-1:0]    used_q [NUM_SLOTS], used_d [NUM_SLOTS];
  logic [ECNT_W-1:0]    bump_q [NUM_SLOTS], bump_d [NUM_SLOTS];
  logic [ECNT_W-1:0]    size_q [NUM_SLOTS], size_d [NUM_SLOTS];
  logic [LINK_W-1:0]    lhead_q, lhead_d;

  // counters
  logic [10:0] inuse_q, inuse_d;
  logic [4:0]  nblk_q, nblk_d;
  logic [31:0] nalloc_q, nalloc_d, nfree_q, nfree_d, nfail_q, nfail_d;

  // result of the word under work
  status_e           rstat_q, rstat_d;
  logic [SLOT_W-1:0] rblk_q, rblk_d;
  logic [ELEM_W-1:0] ridx_q, ridx_d;

  // output register
  logic        ovld_q, ovld_d;
  status_e     ostat_q;
  logic [SLOT_W-1:0] oblk_q;
  logic [ELEM_W-1:0] oidx_q;
  logic [10:0] oinuse_q;
  logic [4:0]  onblk_q;
  logic [31:0] oalloc_q, ofree_q, ofail_q;
  logic        oload;

  // element memory
  elem_word_t        elem_mem [NUM_SLOTS*MAX_ELEMS];
  elem_word_t        mem_rd_q, mem_wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  // helpers
  logic [SLOT_W-1:0] cs;          // current slot
  logic [ECNT_W-1:0] ce;          // head element of current slot
  logic [ECNT_W-1:0] eff_size;
  logic              idle_found;
  logic [SLOT_W-1:0] idle_slot;
  logic [LINK_W-1:0] nx, pv;
  logic [ECNT_W-1:0] used_dec;

  assign cs = cur_q[SLOT_W-1:0];
  assign ce = fhead_q[cs];

  // block size clamp
  always_comb begin
    eff_size = blk_size_q;
    if (blk_size_q < ECNT_W'(2)) eff_size = ECNT_W'(2);
    if (blk_size_q > ELM_NIL)    eff_size = ELM_NIL;
  end

  // lowest idle slot
  always_comb begin
    idle_found = 1'b0;
    idle_slot  = '0;
    for (int s = NUM_SLOTS-1; s >= 0; s--) begin
      if (!act_q[s]) begin
        idle_found = 1'b1;
        idle_slot  = SLOT_W'(s);
      end
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign oload       = (state_q == ST_DONE) && (!ovld_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    walk_d   = walk_q;
    fblk_d   = fblk_q;
    fidx_d   = fidx_q;
    act_d    = act_q;
    nxt_d    = nxt_q;
    prv_d    = prv_q;
    fhead_d  = fhead_q;
    used_d   = used_q;
    bump_d   = bump_q;
    size_d   = size_q;
    lhead_d  = lhead_q;
    inuse_d  = inuse_q;
    nblk_d   = nblk_q;
    nalloc_d = nalloc_q;
    nfree_d  = nfree_q;
    nfail_d  = nfail_q;
    rstat_d  = rstat_q;
    rblk_d   = rblk_q;
    ridx_d   = ridx_q;
    mem_we    = 1'b0;
    mem_waddr = {cs, ce[ELEM_W-1:0]};
    mem_wdata = '{used: 1'b1, link: ELM_NIL};
    mem_raddr = {cs, ce[ELEM_W-1:0]};
    nx        = nxt_q[fblk_q];
    pv        = prv_q[fblk_q];
    used_dec  = used_q[fblk_q] - ECNT_W'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          fblk_d = req_i.free_block;
          fidx_d = req_i.free_index;
          cur_d  = lhead_q;
          walk_d = '0;
          rblk_d = '0;
          ridx_d = '0;
          state_d = req_i.operation ? ST_FCHK : ST_WALK;
        end
      end

      // one block of the list a cycle
      ST_WALK: begin
        if (cur_q == BLK_NIL || walk_q >= LINK_W'(NUM_SLOTS)) begin
          if (grow_q || lhead_q == BLK_NIL) begin
            state_d = ST_CREATE;
          end else begin
            rstat_d = STATUS_ALLOC_FAIL;
            nfail_d = nfail_q + 32'd1;
            state_d = ST_DONE;
          end
        end else if (ce != ELM_NIL) begin
          state_d = ST_POP;
        end else begin
          cur_d  = nxt_q[cs];
          walk_d = walk_q + LINK_W'(1);
        end
      end

      // new block in the lowest idle slot, linked at the head
      ST_CREATE: begin
        if (!idle_found) begin
          rstat_d = STATUS_ALLOC_FAIL;
          nfail_d = nfail_q + 32'd1;
          state_d = ST_DONE;
        end else begin
          act_d[idle_slot]   = 1'b1;
          fhead_d[idle_slot] = '0;
          used_d[idle_slot]  = '0;
          bump_d[idle_slot]  = '0;
          size_d[idle_slot]  = eff_size;
          prv_d[idle_slot]   = BLK_NIL;
          nxt_d[idle_slot]   = lhead_q;
          if (lhead_q != BLK_NIL) prv_d[lhead_q[SLOT_W-1:0]] = {1'b0, idle_slot};
          lhead_d = {1'b0, idle_slot};
          nblk_d  = nblk_q + 5'd1;
          cur_d   = {1'b0, idle_slot};
          state_d = ST_POP;
        end
      end

      // pop the head element: untouched ones come from the bump pointer
      ST_POP: begin
        rstat_d = STATUS_OK;
        rblk_d  = cs;
        ridx_d  = ce[ELEM_W-1:0];
        if (ce == bump_q[cs]) begin
          mem_we      = 1'b1;
          bump_d[cs]  = ce + ECNT_W'(1);
          fhead_d[cs] = (ce + ECNT_W'(1) < size_q[cs]) ? ce + ECNT_W'(1) : ELM_NIL;
          used_d[cs]  = used_q[cs] + ECNT_W'(1);
          inuse_d     = inuse_q + 11'd1;
          nalloc_d    = nalloc_q + 32'd1;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_ARD;
        end
      end

      // link of a recycled element arrives from the memory
      ST_ARD: begin
        mem_we      = 1'b1;
        mem_wdata   = '{used: 1'b1, link: mem_rd_q.link};
        fhead_d[cs] = mem_rd_q.link;
        used_d[cs]  = used_q[cs] + ECNT_W'(1);
        inuse_d     = inuse_q + 11'd1;
        nalloc_d    = nalloc_q + 32'd1;
        state_d     = ST_DONE;
      end

      // free: slot active and element ever handed out
      ST_FCHK: begin
        mem_raddr = {fblk_q, fidx_q};
        if (!act_q[fblk_q] || {1'b0, fidx_q} >= bump_q[fblk_q]) begin
          rstat_d = STATUS_BAD_FREE;
          state_d = ST_DONE;
        end else begin
          state_d = ST_FRD;
        end
      end

      ST_FRD: begin
        mem_waddr = {fblk_q, fidx_q};
        if (!mem_rd_q.used) begin
          rstat_d = STATUS_BAD_FREE;
        end else begin
          rstat_d         = STATUS_OK;
          mem_we          = 1'b1;
          mem_wdata       = '{used: 1'b0, link: fhead_q[fblk_q]};
          fhead_d[fblk_q] = {1'b0, fidx_q};
          used_d[fblk_q]  = used_dec;
          inuse_d         = inuse_q - 11'd1;
          nfree_d         = nfree_q + 32'd1;
          // release an empty block that is not the tail, when growth is enabled
          if (used_dec == '0 && grow_q && nx != BLK_NIL) begin
            if (lhead_q == {1'b0, fblk_q}) begin
              lhead_d = nx;
              prv_d[nx[SLOT_W-1:0]] = BLK_NIL;
            end else begin
              if (pv != BLK_NIL) nxt_d[pv[SLOT_W-1:0]] = nx;
              prv_d[nx[SLOT_W-1:0]] = pv;
            end
            act_d[fblk_q]   = 1'b0;
            nxt_d[fblk_q]   = BLK_NIL;
            prv_d[fblk_q]   = BLK_NIL;
            fhead_d[fblk_q] = ELM_NIL;
            nblk_d          = nblk_q - 5'd1;
          end
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (oload) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    ovld_d = ovld_q;
    if (rsp_o.ready) ovld_d = 1'b0;
    if (oload)       ovld_d = 1'b1;
  end

  // control and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      blk_size_q <= ELM_NIL;
      grow_q     <= 1'b1;
      act_q      <= '0;
      lhead_q    <= BLK_NIL;
      inuse_q    <= '0;
      nblk_q     <= '0;
      nalloc_q   <= '0;
      nfree_q    <= '0;
      nfail_q    <= '0;
      ovld_q     <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        nxt_q[s]   <= BLK_NIL;
        prv_q[s]   <= BLK_NIL;
        fhead_q[s] <= ELM_NIL;
        used_q[s]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      lhead_q  <= lhead_d;
      inuse_q  <= inuse_d;
      nblk_q   <= nblk_d;
      nalloc_q <= nalloc_d;
      nfree_q  <= nfree_d;
      nfail_q  <= nfail_d;
      ovld_q   <= ovld_d;
      nxt_q    <= nxt_d;
      prv_q    <= prv_d;
      fhead_q  <= fhead_d;
      used_q   <= used_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BLOCK_SIZE: blk_size_q <= cfg_data_i;
          CFG_GROW:       grow_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    walk_q  <= walk_d;
    fblk_q  <= fblk_d;
    fidx_q  <= fidx_d;
    bump_q  <= bump_d;
    size_q  <= size_d;
    rstat_q <= rstat_d;
    rblk_q  <= rblk_d;
    ridx_q  <= ridx_d;
    if (oload) begin
      ostat_q  <= rstat_q;
      oblk_q   <= rblk_q;
      oidx_q   <= ridx_q;
      oinuse_q <= inuse_q;
      onblk_q  <= nblk_q;
      oalloc_q <= nalloc_q;
      ofree_q  <= nfree_q;
      ofail_q  <= nfail_q;
    end
  end

  // element memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) elem_mem[mem_waddr] <= mem_wdata;
    mem_rd_q <= elem_mem[mem_raddr];
  end

  assign rsp_o.valid         = ovld_q;
  assign rsp_o.status        = ostat_q;
  assign rsp_o.handle_block  = oblk_q;
  assign rsp_o.handle_index  = oidx_q;
  assign rsp_o.in_use_total  = oinuse_q;
  assign rsp_o.blocks_active = onblk_q;
  assign rsp_o.allocs_total  = oalloc_q;
  assign rsp_o.frees_total   = ofree_q;
  assign rsp_o.fails_total   = ofail_q;

  // block count tracks the active bits
  a_nblk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nblk_q == 5'($countones(act_q)))
    else $error("block count out of step with active slots");

  // empty list exactly when no block is active
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lhead_q == BLK_NIL) == (act_q == '0))
    else $error("list head inconsistent with active slots");

  // the walk never visits more than all slots
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk_q <= LINK_W'(NUM_SLOTS)))
    else $error("list walk overran");

  // no memory write outside an update step
  a_mwe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_POP || state_q == ST_ARD || state_q == ST_FRD))
    else $error("element memory written outside an update");

endmodule
